// File: rtl/core/ssfb_pkg.sv
// Shared types, register indexes, reset values and the segment table
// for the seven-segment frame builder. No dependencies.
package ssfb_pkg;

  localparam int unsigned CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DATA_COMMAND    = 2'd0,
    CFG_ADDRESS_COMMAND = 2'd1,
    CFG_DISPLAY_CONTROL = 2'd2
  } cfg_index_t;

  localparam logic [7:0] DATA_COMMAND_RST    = 8'h40;
  localparam logic [7:0] ADDRESS_COMMAND_RST = 8'hC0;
  localparam logic [7:0] DISPLAY_CONTROL_RST = 8'h88;

  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_MINUS = 8'h40;

  // Number of display positions in the digit frame.
  localparam int unsigned NUM_POS = 4;

  typedef struct packed {
    logic [7:0] data_command;
    logic [7:0] address_command;
    logic [7:0] display_control;
  } cfg_t;

  // Segment bytes for the four display positions, position 0 first.
  typedef struct packed {
    logic [NUM_POS-1:0][7:0] seg;
  } digit_frame_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h30;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h79;
      4'd4:    code = 8'h74;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h6F;
      4'd7:    code = 8'h38;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h7D;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/core/ssfb_cfg_regs.sv
// Command byte registers of the frame builder, written over the
// configuration channel. Depends on ssfb_pkg.
module ssfb_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  output ssfb_pkg::cfg_t                  cfg
);
  import ssfb_pkg::*;

  logic cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // An index outside the register list is accepted and dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_command    <= DATA_COMMAND_RST;
      cfg.address_command <= ADDRESS_COMMAND_RST;
      cfg.display_control <= DISPLAY_CONTROL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DATA_COMMAND:    cfg.data_command    <= cfg_data;
        CFG_ADDRESS_COMMAND: cfg.address_command <= cfg_data;
        CFG_DISPLAY_CONTROL: cfg.display_control <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/ssfb_encode.sv
// Input register and digit encoder: clamps the held value to -999..999 and
// forms the four segment bytes of the digit frame. Depends on ssfb_pkg.
module ssfb_encode (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [15:0]     value,
  output logic                   enc_valid,
  input  logic                   enc_take,
  output ssfb_pkg::digit_frame_t enc_frame
);
  import ssfb_pkg::*;

  localparam logic signed [15:0] VAL_MAX = 16'sd999;
  localparam logic signed [15:0] VAL_MIN = -16'sd999;

  logic               full;
  logic signed [15:0] value_q;
  logic               load_in;

  logic signed [15:0] clamped;
  logic               neg;
  logic [15:0]        abs_val;
  logic [9:0]         mag;
  logic [17:0]        prod_tens;
  logic [15:0]        prod_hund;
  logic [6:0]         quot_ten;
  logic [3:0]         hund;
  logic [9:0]         ten_quot_ten;
  logic [9:0]         rem_units;
  logic [6:0]         ten_hund;
  logic [6:0]         rem_tens;
  logic [7:0]         seg0;
  logic [7:0]         seg1;
  logic [7:0]         seg2;
  logic [7:0]         sign_byte;

  assign in_stall  = full && !enc_take;
  assign load_in   = in_valid && !in_stall;
  assign enc_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load_in) begin
      full <= 1'b1;
    end else if (enc_take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      value_q <= value;
    end
  end

  // Division by ten and by one hundred use reciprocal products that are
  // exact over the clamped magnitude range 0..999.
  always_comb begin
    if (value_q > VAL_MAX) begin
      clamped = VAL_MAX;
    end else if (value_q < VAL_MIN) begin
      clamped = VAL_MIN;
    end else begin
      clamped = value_q;
    end
    neg          = clamped[15];
    abs_val      = neg ? 16'(-clamped) : 16'(clamped);
    mag          = abs_val[9:0];
    prod_tens    = {8'd0, mag} * 18'd205;
    prod_hund    = {6'd0, mag} * 16'd41;
    quot_ten     = prod_tens[17:11];
    hund         = prod_hund[15:12];
    ten_quot_ten = {quot_ten, 3'b000} + {2'b00, quot_ten, 1'b0};
    rem_units    = mag - ten_quot_ten;
    ten_hund     = {hund, 3'b000} + {2'b00, hund, 1'b0};
    rem_tens     = quot_ten - ten_hund;
    seg0         = seg_code(rem_units[3:0]);
    seg1         = seg_code(rem_tens[3:0]);
    seg2         = seg_code(hund);
    sign_byte    = neg ? SEG_MINUS : SEG_BLANK;

    enc_frame.seg[0] = seg0;
    if (mag < 10'd10) begin
      enc_frame.seg[1] = sign_byte;
      enc_frame.seg[2] = SEG_BLANK;
      enc_frame.seg[3] = SEG_BLANK;
    end else if (mag < 10'd100) begin
      enc_frame.seg[1] = seg1;
      enc_frame.seg[2] = sign_byte;
      enc_frame.seg[3] = SEG_BLANK;
    end else begin
      enc_frame.seg[1] = seg1;
      enc_frame.seg[2] = seg2;
      enc_frame.seg[3] = sign_byte;
    end
  end

endmodule

// File: rtl/core/ssfb_serializer.sv
// Frame register and byte sequencer: sends the seven bytes of one display
// write with their start, stop and last markers. Depends on ssfb_pkg.
module ssfb_serializer (
  input  logic                   clk,
  input  logic                   rst,
  input  ssfb_pkg::cfg_t         cfg,
  input  logic                   enc_valid,
  output logic                   enc_take,
  input  ssfb_pkg::digit_frame_t enc_frame,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             frame_byte,
  output logic                   start_before,
  output logic                   stop_after,
  output logic                   last
);
  import ssfb_pkg::*;

  localparam logic [2:0] BYTE_DATA_CMD  = 3'd0;
  localparam logic [2:0] BYTE_ADDR_CMD  = 3'd1;
  localparam logic [2:0] BYTE_POS0      = 3'd2;
  localparam logic [2:0] BYTE_POS1      = 3'd3;
  localparam logic [2:0] BYTE_POS2      = 3'd4;
  localparam logic [2:0] BYTE_POS3      = 3'd5;
  localparam logic [2:0] BYTE_LAST      = 3'd6;

  logic         busy;
  logic [2:0]   cnt;
  digit_frame_t frame;
  logic         out_fire;
  logic         done;

  assign out_valid = busy;
  assign out_fire  = busy && !out_stall;
  assign done      = out_fire && (cnt == BYTE_LAST);
  // The next frame loads in the same cycle that the last byte leaves.
  assign enc_take  = enc_valid && (!busy || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= BYTE_DATA_CMD;
    end else if (enc_take) begin
      busy <= 1'b1;
      cnt  <= BYTE_DATA_CMD;
    end else if (done) begin
      busy <= 1'b0;
      cnt  <= BYTE_DATA_CMD;
    end else if (out_fire) begin
      cnt  <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (enc_take) begin
      frame <= enc_frame;
    end
  end

  always_comb begin
    start_before = 1'b0;
    stop_after   = 1'b0;
    last         = 1'b0;
    case (cnt)
      BYTE_DATA_CMD: begin
        frame_byte   = cfg.data_command;
        start_before = 1'b1;
        stop_after   = 1'b1;
      end
      BYTE_ADDR_CMD: begin
        frame_byte   = cfg.address_command;
        start_before = 1'b1;
      end
      BYTE_POS0: frame_byte = frame.seg[0];
      BYTE_POS1: frame_byte = frame.seg[1];
      BYTE_POS2: frame_byte = frame.seg[2];
      BYTE_POS3: begin
        frame_byte = frame.seg[3];
        stop_after = 1'b1;
      end
      BYTE_LAST: begin
        frame_byte   = cfg.display_control;
        start_before = 1'b1;
        stop_after   = 1'b1;
        last         = 1'b1;
      end
      default: frame_byte = SEG_BLANK;
    endcase
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt <= BYTE_LAST))
    else $error("byte counter beyond the last byte of a frame");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (out_fire && (cnt != BYTE_LAST)) |=> (busy && (cnt == 3'($past(cnt) + 3'd1))))
    else $error("byte counter did not advance after a transaction");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (busy && out_stall) |=> (busy && $stable(cnt)))
    else $error("sequencer moved while the output was stalled");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (start_before && stop_after))
    else $error("last byte is not framed by start and stop");
`endif

endmodule

// File: rtl/core/seven_segment_frame_builder.sv
// Seven-segment frame builder, top level.
// A value passes the input register, then the frame register, before its first byte is valid.
// Bytes leave one per cycle while out_stall is low, set by the output sequencer;
// the input register takes the next value while the current frame is sent.
// Reset: synchronous rst empties both stages and loads the command registers
// with 0x40, 0xC0 and 0x88.
module seven_segment_frame_builder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      frame_byte,
  output logic                            start_before,
  output logic                            stop_after,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);
  import ssfb_pkg::*;

  cfg_t         cfg;
  logic         enc_valid;
  logic         enc_take;
  digit_frame_t enc_frame;

  ssfb_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssfb_encode u_encode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .enc_valid (enc_valid),
    .enc_take  (enc_take),
    .enc_frame (enc_frame)
  );

  ssfb_serializer u_serializer (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .enc_valid    (enc_valid),
    .enc_take     (enc_take),
    .enc_frame    (enc_frame),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_byte   (frame_byte),
    .start_before (start_before),
    .stop_after   (stop_after),
    .last         (last)
  );

endmodule
